### hdl/cv_keyframe_interpolator_macros.svh
// Assertion helpers for the keyframe interpolator.
// Both forms expect clk and rst_n in scope.
`ifndef CV_KEYFRAME_INTERPOLATOR_MACROS_SVH
`define CV_KEYFRAME_INTERPOLATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KFI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KFI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/kfi_pkg.sv
// ----------------------------------------------------------------------------
// kfi_pkg
// Types, codes and constants shared by the keyframe interpolator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kfi_pkg;

  localparam int COLUMNS_DEF   = 16;
  localparam int MAX_LINES_DEF = 256;

  // input item kinds (carried on in_tuser)
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // configuration register indexes
  localparam int          CFG_IDX_W   = 2;
  localparam int          CFG_DATA_W  = 16;
  localparam logic [1:0]  CFG_LPB     = 2'd0;
  localparam logic [1:0]  CFG_PLEN    = 2'd1;
  localparam logic [1:0]  CFG_BPMMASK = 2'd2;

  localparam logic [6:0]  LPB_RST  = 7'd4;
  localparam logic [8:0]  PLEN_RST = 9'd64;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  localparam int LEVEL_W = 18;
  localparam int TOTAL_W = 31;
  localparam int LINE_W  = 15;
  localparam int F99_W   = 23;

  localparam logic [9:0]  VALUE_MAX = 10'd999;
  localparam logic [6:0]  DELAY_MAX = 7'd99;
  localparam int          STEPS_PER_LINE = 99;

  localparam logic [LEVEL_W-1:0] LEVEL_CV_DEF    = 18'd128000;
  localparam logic [LEVEL_W-1:0] LEVEL_TEMPO_DEF = 18'd30720;
  localparam logic [LEVEL_W-1:0] LEVEL_TEMPO_MIN = 18'd7680;
  localparam logic [LEVEL_W-1:0] LEVEL_TEMPO_MAX = 18'd76800;

  typedef struct packed {
    logic       set;
    logic [9:0] value;
    logic [6:0] delay;
  } kfi_entry_t;

  localparam int ENTRY_W = $bits(kfi_entry_t);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINE,
    ST_CUR,
    ST_CUR_CHK,
    ST_BACK,
    ST_FWD,
    ST_SPAN,
    ST_MAC,
    ST_DIV_GO,
    ST_DIV,
    ST_FIN
  } kfi_state_t;

endpackage

`default_nettype wire

### hdl/kfi_ram.sv
// ----------------------------------------------------------------------------
// kfi_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kfi_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/kfi_div.sv
// ----------------------------------------------------------------------------
// kfi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kfi_div #(
  parameter int NUMW = 33,
  parameter int DENW = 15
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            done,
  output logic [NUMW-1:0] quot
);

  localparam int CNTW = $clog2(NUMW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [NUMW-1:0] q_r, q_nxt;
  logic [DENW-1:0] rem_r, rem_nxt;
  logic [DENW:0]   rem_sh;

  assign rem_sh = {rem_r, q_r[NUMW-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(NUMW);
      q_nxt    = num;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // trial subtract the shifted remainder
      if (rem_sh >= {1'b0, den}) begin
        rem_nxt = DENW'(rem_sh - {1'b0, den});
        q_nxt   = {q_r[NUMW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DENW-1:0];
        q_nxt   = {q_r[NUMW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

### hdl/cv_keyframe_interpolator.sv
// ----------------------------------------------------------------------------
// cv_keyframe_interpolator
// Per-column keyframe store with piecewise-linear evaluation at a play time.
// ----------------------------------------------------------------------------
// A write transaction (in_tuser low) loads one keyframe entry and gives no
// result. In an evaluate transaction (in_tuser high) the backward and forward
// searches read one entry a cycle from the single keyframe RAM read port, a
// shared 10 x 16 multiplier builds the numerator in four steps and a
// one-bit-a-cycle divider produces the level. After reset the block sweeps all
// COLUMNS * MAX_LINES entries (4096 by default) of the store to not set, with
// in_tready low; configuration writes are taken throughout. A finished result
// waits in the output register while the next transaction is accepted.
`default_nettype none

module cv_keyframe_interpolator
  import kfi_pkg::*;
#(
  parameter int COLUMNS   = kfi_pkg::COLUMNS_DEF,
  parameter int MAX_LINES = kfi_pkg::MAX_LINES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [kfi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kfi_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // column[3:0], line_index[11:4], key_set[12], key_value[22:13],
  // key_delay[29:23], beat[37:30], beat_phase[53:38], zero[55:54]
  input  logic [kfi_pkg::IN_DATA_W-1:0]      in_tdata,
  // cmd
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_column[3:0], level_q8[21:4], play_line[29:22], out_of_range[30],
  // zero[31]
  output logic [kfi_pkg::OUT_DATA_W-1:0]     out_tdata,
  // is_tempo
  output logic                               out_tuser
);

  `include "cv_keyframe_interpolator_macros.svh"

  localparam int DEPTH = COLUMNS * MAX_LINES;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(MAX_LINES);
  localparam int LENW  = $clog2(MAX_LINES + 1);
  localparam int PW    = $clog2(MAX_LINES * STEPS_PER_LINE + 1);
  localparam int DW    = PW + 16;
  localparam int MW    = (PW > 16) ? PW : 16;
  localparam int NW    = DW + 10;
  localparam int NUMW  = NW - 8;

  // input fields
  logic [3:0]  in_col;
  logic [7:0]  in_li;
  logic        in_kset;
  logic [9:0]  in_kval;
  logic [6:0]  in_kdly;
  logic [7:0]  in_beat;
  logic [15:0] in_phase;

  assign in_col   = in_tdata[3:0];
  assign in_li    = in_tdata[11:4];
  assign in_kset  = in_tdata[12];
  assign in_kval  = in_tdata[22:13];
  assign in_kdly  = in_tdata[29:23];
  assign in_beat  = in_tdata[37:30];
  assign in_phase = in_tdata[53:38];

  // configuration
  logic [6:0]  lpb_r;
  logic [8:0]  plen_r;
  logic [15:0] mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpb_r  <= LPB_RST;
      plen_r <= PLEN_RST;
      mask_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LPB:     lpb_r  <= cfg_wdata[6:0];
        CFG_PLEN:    plen_r <= cfg_wdata[8:0];
        CFG_BPMMASK: mask_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // state
  kfi_state_t         state_r, state_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [3:0]         col_r, col_nxt;
  logic               tempo_r, tempo_nxt;
  logic               colok_r, colok_nxt;
  logic               oor_r, oor_nxt;
  logic               hf_r, hf_nxt, ht_r, ht_nxt;
  logic [LW-1:0]      lf_r, lf_nxt, lt_r, lt_nxt;
  kfi_entry_t         ef_r, ef_nxt, et_r, et_nxt;
  logic [LENW-1:0]    sc_idx_r, sc_idx_nxt;
  logic               sc_more_r, sc_more_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [LW-1:0]      chk_idx_r, chk_idx_nxt;
  logic [PW-1:0]      dd_r, dd_nxt;
  logic [DW-1:0]      n_r, n_nxt, dn_r, dn_nxt;
  logic [NW-1:0]      acc_r, acc_nxt;
  logic [1:0]         mac_k_r, mac_k_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;

  logic               out_vld_r, out_vld_nxt;
  logic [3:0]         out_col_r, out_col_nxt;
  logic [LEVEL_W-1:0] out_level_r, out_level_nxt;
  logic [7:0]         out_line_r, out_line_nxt;
  logic               out_oor_r, out_oor_nxt;
  logic               out_tempo_r, out_tempo_nxt;

  // memory and divider connections
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [ENTRY_W-1:0] wr_data, rd_data;
  kfi_entry_t         rd_ent;
  logic               div_start, div_done;
  logic [NUMW-1:0]    div_quot;

  // derived values
  logic [LINE_W-1:0]  line;
  logic [15:0]        frac;
  logic [LW-1:0]      line_lw;
  logic [LENW-1:0]    len_eff;
  logic [F99_W-1:0]   frac99;
  logic [PW-1:0]      a_pos, b_pos, t_pos;
  logic [DW-1:0]      a_full, b_full, t_full;
  logic               span_ok;
  logic [9:0]         mac_a;
  logic [MW-1:0]      mac_b;
  logic [10+MW-1:0]   mac_p;
  logic               scan_hit, scan_end;
  logic [LENW-1:0]    line_inc;
  logic               acc_ok;
  kfi_entry_t         wr_ent;

  assign line    = total_r[TOTAL_W-1:16];
  assign frac    = total_r[15:0];
  assign line_lw = line[LW-1:0];
  assign len_eff = (32'(plen_r) > 32'(MAX_LINES)) ? LENW'(MAX_LINES) : LENW'(plen_r);
  assign frac99  = F99_W'(32'(frac) * STEPS_PER_LINE);
  assign a_pos   = PW'(32'(lf_r) * STEPS_PER_LINE + 32'(ef_r.delay));
  assign b_pos   = PW'(32'(lt_r) * STEPS_PER_LINE + 32'(et_r.delay));
  assign t_pos   = PW'(32'(line_lw) * STEPS_PER_LINE);
  // full positions in units of 1/(99*65536) line
  assign a_full  = {a_pos, 16'd0};
  assign b_full  = {b_pos, 16'd0};
  assign t_full  = {t_pos, 16'd0} + DW'(frac99);
  assign span_ok = (b_full > a_full) && (t_full >= a_full) && (t_full <= b_full);
  assign line_inc = LENW'(line_lw) + LENW'(1);

  assign rd_ent   = kfi_entry_t'(rd_data);
  assign scan_hit = chk_vld_r && rd_ent.set;
  assign scan_end = scan_hit || (!sc_more_r && !chk_vld_r);

  always_comb begin
    case (mac_k_r)
      2'd0:    mac_b = MW'(dn_r[15:0]);
      2'd1:    mac_b = MW'(dn_r[DW-1:16]);
      2'd2:    mac_b = MW'(n_r[15:0]);
      default: mac_b = MW'(n_r[DW-1:16]);
    endcase
  end
  assign mac_a  = mac_k_r[1] ? et_r.value : ef_r.value;
  assign mac_p  = (10+MW)'(mac_a) * (10+MW)'(mac_b);
  assign acc_ok = 1'b1;

  assign wr_ent.set   = in_kset;
  assign wr_ent.value = (in_kval > VALUE_MAX) ? VALUE_MAX : in_kval;
  assign wr_ent.delay = (in_kdly > DELAY_MAX) ? DELAY_MAX : in_kdly;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    total_nxt     = total_r;
    col_nxt       = col_r;
    tempo_nxt     = tempo_r;
    colok_nxt     = colok_r;
    oor_nxt       = oor_r;
    hf_nxt        = hf_r;
    ht_nxt        = ht_r;
    lf_nxt        = lf_r;
    lt_nxt        = lt_r;
    ef_nxt        = ef_r;
    et_nxt        = et_r;
    sc_idx_nxt    = sc_idx_r;
    sc_more_nxt   = sc_more_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    dd_nxt        = dd_r;
    n_nxt         = n_r;
    dn_nxt        = dn_r;
    acc_nxt       = acc_r;
    mac_k_nxt     = mac_k_r;
    level_nxt     = level_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_col_nxt   = out_col_r;
    out_level_nxt = out_level_r;
    out_line_nxt  = out_line_r;
    out_oor_nxt   = out_oor_r;
    out_tempo_nxt = out_tempo_r;
    wr_en         = 1'b0;
    wr_addr       = clr_addr_r;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = AW'(32'(col_r) * MAX_LINES + 32'(line_lw));
    div_start     = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == CMD_WRITE) begin
            wr_en   = (32'(in_col) < COLUMNS) && (32'(in_li) < MAX_LINES);
            wr_addr = AW'(32'(in_col) * MAX_LINES + 32'(in_li));
            wr_data = wr_ent;
          end else begin
            total_nxt = TOTAL_W'({in_beat, in_phase}) * TOTAL_W'(lpb_r);
            col_nxt   = in_col;
            tempo_nxt = mask_r[in_col];
            colok_nxt = 32'(in_col) < COLUMNS;
            state_nxt = ST_LINE;
          end
        end
      end

      ST_LINE: begin
        oor_nxt   = 32'(line) >= 32'(len_eff);
        level_nxt = tempo_r ? LEVEL_TEMPO_DEF : LEVEL_CV_DEF;
        hf_nxt    = 1'b0;
        ht_nxt    = 1'b0;
        if ((32'(line) >= 32'(len_eff)) || !colok_r) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_CUR;
        end
      end

      ST_CUR: begin
        rd_en     = 1'b1;
        state_nxt = ST_CUR_CHK;
      end

      ST_CUR_CHK: begin
        chk_vld_nxt = 1'b0;
        if (rd_ent.set && (32'(frac99) >= {9'd0, rd_ent.delay, 16'd0})) begin
          // keyframe on this line already passed: search forward only
          hf_nxt      = 1'b1;
          lf_nxt      = line_lw;
          ef_nxt      = rd_ent;
          sc_idx_nxt  = line_inc;
          sc_more_nxt = line_inc < len_eff;
          state_nxt   = ST_FWD;
        end else begin
          if (rd_ent.set) begin
            ht_nxt = 1'b1;
            lt_nxt = line_lw;
            et_nxt = rd_ent;
          end
          sc_idx_nxt  = LENW'(line_lw) - LENW'(1);
          sc_more_nxt = line_lw != '0;
          state_nxt   = ST_BACK;
        end
      end

      ST_BACK, ST_FWD: begin
        if (scan_end) begin
          chk_vld_nxt = 1'b0;
          if (state_r == ST_BACK) begin
            if (scan_hit) begin
              hf_nxt = 1'b1;
              lf_nxt = chk_idx_r;
              ef_nxt = rd_ent;
            end
            if (!ht_r) begin
              sc_idx_nxt  = line_inc;
              sc_more_nxt = line_inc < len_eff;
              state_nxt   = ST_FWD;
            end else begin
              state_nxt = ST_SPAN;
            end
          end else begin
            if (scan_hit) begin
              ht_nxt = 1'b1;
              lt_nxt = chk_idx_r;
              et_nxt = rd_ent;
            end
            state_nxt = ST_SPAN;
          end
        end else if (sc_more_r) begin
          // issue one read a cycle, check it the cycle after
          rd_en       = 1'b1;
          rd_addr     = AW'(32'(col_r) * MAX_LINES + 32'(sc_idx_r[LW-1:0]));
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = sc_idx_r[LW-1:0];
          if (state_r == ST_BACK) begin
            sc_idx_nxt  = sc_idx_r - LENW'(1);
            sc_more_nxt = sc_idx_r != '0;
          end else begin
            sc_idx_nxt  = sc_idx_r + LENW'(1);
            sc_more_nxt = (sc_idx_r + LENW'(1)) < len_eff;
          end
        end else begin
          chk_vld_nxt = 1'b0;
        end
      end

      ST_SPAN: begin
        state_nxt = ST_FIN;
        if (hf_r && ht_r) begin
          if (span_ok) begin
            dd_nxt    = b_pos - a_pos;
            n_nxt     = t_full - a_full;
            dn_nxt    = b_full - t_full;
            acc_nxt   = '0;
            mac_k_nxt = 2'd0;
            state_nxt = ST_MAC;
          end else begin
            level_nxt = {ef_r.value, 8'd0};
          end
        end else if (hf_r) begin
          level_nxt = {ef_r.value, 8'd0};
        end else if (ht_r) begin
          level_nxt = {et_r.value, 8'd0};
        end
      end

      ST_MAC: begin
        // accumulate vf*(d-n) + vt*n in 16-bit slices
        if (mac_k_r[0]) begin
          acc_nxt = acc_r + (NW'(mac_p) << 16);
        end else begin
          acc_nxt = acc_r + NW'(mac_p);
        end
        mac_k_nxt = mac_k_r + 2'd1;
        if (mac_k_r == 2'd3) begin
          state_nxt = ST_DIV_GO;
        end
      end

      ST_DIV_GO: begin
        div_start = acc_ok;
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        if (div_done) begin
          level_nxt = div_quot[LEVEL_W-1:0];
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt   = 1'b1;
          out_col_nxt   = col_r;
          out_line_nxt  = line[7:0];
          out_oor_nxt   = oor_r;
          out_tempo_nxt = tempo_r;
          out_level_nxt = level_r;
          if (tempo_r) begin
            if (level_r < LEVEL_TEMPO_MIN) out_level_nxt = LEVEL_TEMPO_MIN;
            if (level_r > LEVEL_TEMPO_MAX) out_level_nxt = LEVEL_TEMPO_MAX;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      out_vld_r  <= 1'b0;
      chk_vld_r  <= 1'b0;
      sc_more_r  <= 1'b0;
      hf_r       <= 1'b0;
      ht_r       <= 1'b0;
      mac_k_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      out_vld_r  <= out_vld_nxt;
      chk_vld_r  <= chk_vld_nxt;
      sc_more_r  <= sc_more_nxt;
      hf_r       <= hf_nxt;
      ht_r       <= ht_nxt;
      mac_k_r    <= mac_k_nxt;
    end
    total_r     <= total_nxt;
    col_r       <= col_nxt;
    tempo_r     <= tempo_nxt;
    colok_r     <= colok_nxt;
    oor_r       <= oor_nxt;
    lf_r        <= lf_nxt;
    lt_r        <= lt_nxt;
    ef_r        <= ef_nxt;
    et_r        <= et_nxt;
    sc_idx_r    <= sc_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    dd_r        <= dd_nxt;
    n_r         <= n_nxt;
    dn_r        <= dn_nxt;
    acc_r       <= acc_nxt;
    level_r     <= level_nxt;
    out_col_r   <= out_col_nxt;
    out_level_r <= out_level_nxt;
    out_line_r  <= out_line_nxt;
    out_oor_r   <= out_oor_nxt;
    out_tempo_r <= out_tempo_nxt;
  end

  kfi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kfi_div #(
    .NUMW (NUMW),
    .DENW (PW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r[NW-1:8]),
    .den   (dd_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_tempo_r;
  assign out_tdata  = {1'b0, out_oor_r, out_line_r, out_level_r, out_col_r};

  `KFI_ASSERT_NOW(a_tempo_clamped, out_vld_r && out_tempo_r,
    (out_level_r >= LEVEL_TEMPO_MIN) && (out_level_r <= LEVEL_TEMPO_MAX),
    "tempo level outside clamp range")
  `KFI_ASSERT_NOW(a_oor_default, out_vld_r && out_oor_r,
    (out_level_r == (out_tempo_r ? LEVEL_TEMPO_DEF : LEVEL_CV_DEF)),
    "out of range result without default level")
  `KFI_ASSERT_NOW(a_div_nonzero, div_start, dd_r != '0,
    "divider started on a zero span")
  `KFI_ASSERT_NEXT(a_fin_holds, (state_r == ST_FIN) && out_vld_r && !out_tready,
    (state_r == ST_FIN) && $stable(out_level_r),
    "result overwrote a stalled output")

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyframe interpolator.
// ----------------------------------------------------------------------------
// Keyframe writes and evaluations stream in through the input channel. A
// behavioural copy of the keyframe tables and registers predicts each level.
// Results are compared in order, field by field. Register settings change
// between phases, once no transaction is in flight.

module tb;
  import kfi_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;
  localparam longint unsigned POS_STEP = 64'd6488064;

  typedef struct {
    logic        cmd;
    logic [3:0]  column;
    logic [7:0]  line_index;
    logic        key_set;
    logic [9:0]  key_value;
    logic [6:0]  key_delay;
    logic [7:0]  beat;
    logic [15:0] beat_phase;
  } kf_item_t;

  typedef struct {
    logic [3:0]  column;
    logic [17:0] level_q8;
    logic        is_tempo;
    logic [7:0]  play_line;
    logic        out_of_range;
  } kf_level_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;

  cv_keyframe_interpolator DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // shadow of the block's tables and registers
  logic [17:0] kf_store [16][256];
  int unsigned lpb_r, plen_r, tempo_mask_r;

  kf_item_t  stim_q[$];
  kf_level_t due_levels[$];
  kf_item_t  drive_item;
  int  send_gap, recv_stall;
  bit  no_gaps;
  bit  sender_hold;
  int  errors, n_writes, n_evals, n_oor, n_tempo, idle_cycles;

  initial forever #1 clk = ~clk;

  function automatic longint unsigned kf_pos(longint unsigned ln, logic [17:0] e);
    return (ln * 99 + e[6:0]) * 65536;
  endfunction

  function automatic kf_level_t interpolate_level(kf_item_t it);
    kf_level_t r;
    longint unsigned total, ln, frac, len, level, pf, pt, t, vf, vt, d, n;
    logic [17:0] ef, et, cur;
    bit hf, ht, tempo;
    hf = 0; ht = 0; ef = '0; et = '0;
    total = ((longint'(it.beat) << 16) + it.beat_phase) * lpb_r;
    ln = total >> 16;
    frac = total & 64'hFFFF;
    len = (plen_r > 256) ? 256 : plen_r;
    tempo = tempo_mask_r[it.column];
    level = tempo ? 120 * 256 : 500 * 256;
    r.out_of_range = (ln >= len);
    if (!r.out_of_range) begin
      cur = kf_store[it.column][ln];
      if (cur[17]) begin
        if (frac * 99 >= longint'(cur[6:0]) * 65536) begin
          hf = 1; pf = kf_pos(ln, cur); ef = cur;
        end else begin
          ht = 1; pt = kf_pos(ln, cur); et = cur;
        end
      end
      if (!hf)
        for (longint unsigned i = ln; i > 0; i--)
          if (kf_store[it.column][i-1][17]) begin
            hf = 1; ef = kf_store[it.column][i-1]; pf = kf_pos(i - 1, ef);
            break;
          end
      if (!ht)
        for (longint unsigned i = ln + 1; i < len; i++)
          if (kf_store[it.column][i][17]) begin
            ht = 1; et = kf_store[it.column][i]; pt = kf_pos(i, et);
            break;
          end
      vf = longint'(ef[16:7]) * 256;
      vt = longint'(et[16:7]) * 256;
      t = ln * POS_STEP + frac * 99;
      if (hf && ht) begin
        if (pt > pf && t >= pf && t <= pt) begin
          d = pt - pf;
          n = t - pf;
          level = (vf * (d - n) + vt * n) / d;
        end else begin
          level = vf;
        end
      end else if (hf) begin
        level = vf;
      end else if (ht) begin
        level = vt;
      end
    end
    if (tempo) begin
      if (level < 7680) level = 7680;
      if (level > 76800) level = 76800;
    end
    r.column = it.column;
    r.level_q8 = level[17:0];
    r.is_tempo = tempo;
    r.play_line = ln[7:0];
    return r;
  endfunction

  task automatic apply_item(kf_item_t it);
    kf_level_t r;
    logic [9:0] v;
    logic [6:0] dl;
    if (it.cmd == CMD_WRITE) begin
      v = (it.key_value > VALUE_MAX) ? VALUE_MAX : it.key_value;
      dl = (it.key_delay > DELAY_MAX) ? DELAY_MAX : it.key_delay;
      kf_store[it.column][it.line_index] = {it.key_set, v, dl};
      n_writes++;
    end else begin
      r = interpolate_level(it);
      due_levels.push_back(r);
      n_evals++;
      if (r.out_of_range) n_oor++;
      if (r.is_tempo) n_tempo++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) apply_item(drive_item);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (stim_q.size() > 0 && !sender_hold) begin
          drive_item = stim_q.pop_front();
          in_tuser <= drive_item.cmd;
          in_tdata <= {2'b00, drive_item.beat_phase, drive_item.beat, drive_item.key_delay,
                       drive_item.key_value, drive_item.key_set, drive_item.line_index,
                       drive_item.column};
          in_tvalid <= 1'b1;
          send_gap <= no_gaps ? 0 : $urandom_range(0, 8);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    kf_level_t exp_r;
    int stall_next;
    stall_next = recv_stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_levels.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: %h", out_tdata);
        end else begin
          exp_r = due_levels.pop_front();
          if (out_tdata[3:0] !== exp_r.column || out_tdata[21:4] !== exp_r.level_q8 ||
              out_tuser !== exp_r.is_tempo || out_tdata[29:22] !== exp_r.play_line ||
              out_tdata[30] !== exp_r.out_of_range) begin
            errors++;
            if (errors <= 10)
              $display({"level mismatch: exp col %0d lvl %0d tempo %0d line %0d oor %0d,",
                        " got col %0d lvl %0d tempo %0d line %0d oor %0d"},
                       exp_r.column, exp_r.level_q8, exp_r.is_tempo, exp_r.play_line,
                       exp_r.out_of_range, out_tdata[3:0], out_tdata[21:4], out_tuser,
                       out_tdata[29:22], out_tdata[30]);
          end
        end
        stall_next = no_gaps ? 0 : $urandom_range(0, 8);
      end
      if (stall_next > 0) begin
        out_tready <= 1'b0;
        recv_stall <= stall_next - 1;
      end else begin
        out_tready <= 1'b1;
        recv_stall <= 0;
      end
    end
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("cv_keyframe_interpolator: mismatch");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[15:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_LPB:     lpb_r = val & 32'h7F;
      CFG_PLEN:    plen_r = val & 32'h1FF;
      CFG_BPMMASK: tempo_mask_r = val & 32'hFFFF;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (stim_q.size() != 0 || in_tvalid || due_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_write(int col, int ln, bit st, int val, int dly);
    kf_item_t it;
    it = '{CMD_WRITE, col[3:0], ln[7:0], st, val[9:0], dly[6:0],
           8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))};
    stim_q.push_back(it);
  endtask

  task automatic push_eval(int col, int bt, int ph);
    kf_item_t it;
    it = '{CMD_EVAL, col[3:0], 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
           10'($urandom_range(0, 1023)), 7'($urandom_range(0, 127)), bt[7:0], ph[15:0]};
    stim_q.push_back(it);
  endtask

  // evaluate at a random time inside the pattern
  task automatic push_eval_in(int col);
    longint unsigned len, target, p;
    len = (plen_r > 256) ? 256 : plen_r;
    target = {$urandom} % (len * 65536);
    if (lpb_r == 0) begin
      push_eval(col, $urandom_range(0, 255), $urandom_range(0, 65535));
    end else begin
      p = target / lpb_r;
      push_eval(col, int'(p >> 16), int'(p & 16'hFFFF));
    end
  endtask

  task automatic random_phase(int items);
    int cnt, col, len, k;
    kf_item_t it;
    cnt = 0;
    len = (plen_r > 256) ? 256 : plen_r;
    while (cnt < items) begin
      if ($urandom_range(0, 9) < 7) begin
        col = $urandom_range(0, 15);
        k = $urandom_range(0, 4);
        for (int i = 0; i < k; i++)
          push_write(col, $urandom_range(0, len - 1), $urandom_range(0, 5) != 0,
                     $urandom_range(0, 1023), $urandom_range(0, 127));
        for (int i = 0; i < 3; i++) push_eval_in(col);
        cnt += k + 3;
      end else begin
        it = '{1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               10'($urandom_range(0, 1023)), 7'($urandom_range(0, 127)),
               8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))};
        stim_q.push_back(it);
        cnt++;
      end
    end
  endtask

  initial begin
    for (int c = 0; c < 16; c++)
      for (int l = 0; l < 256; l++) kf_store[c][l] = '0;
    lpb_r = LPB_RST;
    plen_r = PLEN_RST;
    tempo_mask_r = 0;
    errors = 0; n_writes = 0; n_evals = 0; n_oor = 0; n_tempo = 0; idle_cycles = 0;
    no_gaps = 0;
    sender_hold = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: defaults, holds, interpolation, clamps, saturation, range
    cfg_write(CFG_BPMMASK, 16'h8000);
    push_eval(0, 0, 0);
    push_eval(15, 3, 16'h8000);
    push_write(0, 2, 1, 999, 0);
    push_eval(0, 0, 0);
    push_eval(0, 15, 16'hFFFF);
    push_write(0, 6, 1, 0, 99);
    push_eval(0, 1, 0);
    push_eval(0, 1, 16'h4000);
    push_eval(0, 0, 16'h8000);
    push_write(0, 6, 0, 0, 0);
    push_eval(0, 1, 16'h4000);
    push_write(15, 1, 1, 10, 0);
    push_write(15, 9, 1, 1023, 127);
    push_eval(15, 0, 16'h4000);
    push_eval(15, 2, 16'h4000);
    push_eval(15, 2, 16'hFFFF);
    push_eval(15, 255, 16'hFFFF);
    push_eval(0, 16, 0);
    push_write(0, 255, 1, 500, 50);
    wait_idle();

    // random phases over a spread of settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin cfg_write(CFG_LPB, 1); cfg_write(CFG_PLEN, 256);
                 cfg_write(CFG_BPMMASK, 16'hFFFF); end
        1: begin cfg_write(CFG_LPB, 64); cfg_write(CFG_PLEN, 1);
                 cfg_write(CFG_BPMMASK, 16'h0000); end
        2: begin cfg_write(CFG_LPB, 0); cfg_write(CFG_PLEN, 511);
                 cfg_write(CFG_BPMMASK, 16'hA5A5); end
        3: begin cfg_write(CFG_LPB, 127); cfg_write(CFG_PLEN, 200);
                 cfg_write(CFG_BPMMASK, 16'h5A5A); end
        4: begin cfg_write(CFG_LPB, 2); cfg_write(CFG_PLEN, 16);
                 cfg_write(CFG_BPMMASK, $urandom_range(0, 65535)); end
        5: begin cfg_write(CFG_LPB, 4); cfg_write(CFG_PLEN, 64);
                 cfg_write(CFG_BPMMASK, $urandom_range(0, 65535)); end
        default: begin cfg_write(CFG_LPB, $urandom_range(1, 64));
                 cfg_write(CFG_PLEN, $urandom_range(1, 256));
                 cfg_write(CFG_BPMMASK, $urandom_range(0, 65535)); end
      endcase
      no_gaps = (ph == 5);
      random_phase(60);
      // hold the sender until every pending level has come back
      while (stim_q.size() != 0 || in_tvalid) @(posedge clk);
      sender_hold = 1;
      while (due_levels.size() != 0) @(posedge clk);
      sender_hold = 0;
      random_phase(55);
      wait_idle();
    end

    $display("covered %0d keyframe writes and %0d evaluations", n_writes, n_evals);
    $display("%0d evaluations past the pattern end, %0d on tempo columns", n_oor, n_tempo);
    if (errors == 0)
      $display("cv_keyframe_interpolator: match");
    else
      $display("cv_keyframe_interpolator: mismatch");
    $finish;
  end

endmodule
